### src/dopdq_pkg.sv
// ----------------------------------------------------------------------------
// Drop-oldest deque package
// Shared constants, action and status codes and the transfer payload types
// of the drop-oldest double-ended entry queue.
// ----------------------------------------------------------------------------
package dopdq_pkg;

  // Default geometry of the entry store.
  localparam int STORE_DEPTH_DEF = 256;
  localparam int ENTRY_WIDTH_DEF = 64;

  // Reset value of the max_depth register.
  localparam logic [8:0] MAX_DEPTH_RESET = 9'h0FF;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  // Register addresses.
  localparam logic [PADDR_W-1:0] ADDR_MAX_DEPTH = '0;

  // Action codes.
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_PEEK_FRONT = 3'd3;
  localparam logic [2:0] ACT_STATUS     = 3'd4;

  // Status codes.
  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_EMPTY      = 2'd1;
  localparam logic [1:0] STS_FRONT_FULL = 2'd2;

  // Command transfer.
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] entry_in;
    logic        clear_discards;
  } cmd_t;

  // Result transfer.
  typedef struct packed {
    logic [63:0] entry_out;
    logic        entry_valid;
    logic        evicted;
    logic [1:0]  status;
    logic [8:0]  depth;
    logic [31:0] discard_count;
  } res_t;

endpackage

### src/drop_oldest_packet_deque_unit.sv
// ----------------------------------------------------------------------------
// Drop-oldest packet deque unit
// Bounded double-ended entry queue in a ring store with drop-oldest back
// pushes, front pushes, pop, peek and a saturating discard counter.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on cmd/cmd_valid/cmd_stall and one result per command
//   leaves on res/res_valid/res_stall. A transfer happens at a rising edge
//   with valid high and stall low.
//   A transferred command reads the head entry of the store into a register
//   and moves the block to its execute state; there the block updates head,
//   count and discard counter, writes the pushed entry back and loads the
//   result register, which raises res_valid. The store read lies ahead of
//   the write-back, and the block takes no new command until the one in
//   execution has completed.
//   The result register parts the two sides: a new command is taken while
//   an earlier result still waits. If the receiver stalls and the result
//   register is still full, the command in progress holds until it drains.
//   Reset empties the queue, clears the discard counter and sets max_depth
//   to 255; the store itself is not cleared and needs no clearing pass.
//   User writes max_depth via the APB port only with the queue idle; unchecked.
// ----------------------------------------------------------------------------
module drop_oldest_packet_deque_unit #(
  parameter int STORE_DEPTH = dopdq_pkg::STORE_DEPTH_DEF,
  parameter int ENTRY_WIDTH = dopdq_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command channel
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  dopdq_pkg::cmd_t               cmd,
  // Result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output dopdq_pkg::res_t               res,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dopdq_pkg::PADDR_W-1:0] paddr,
  input  logic [dopdq_pkg::PDATA_W-1:0] pwdata,
  output logic [dopdq_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int CAP_W = (CNT_W > 9) ? CNT_W : 9;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Control state
  logic                   state;
  logic [IDX_W-1:0]       head;
  logic [CNT_W-1:0]       count;
  logic [31:0]            discards;
  logic [8:0]             max_depth;

  // Command held during execution
  dopdq_pkg::cmd_t        cmd_q;

  // Entry store
  logic [ENTRY_WIDTH-1:0] store [STORE_DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;

  // Execution datapath
  logic                   cmd_take;
  logic                   res_free;
  logic                   exec_go;
  logic [IDX_W-1:0]       head_inc;
  logic [IDX_W-1:0]       head_dec;
  logic [SUM_W-1:0]       tail_sum;
  logic [IDX_W-1:0]       tail;
  logic [CAP_W-1:0]       md_ext;
  logic [CAP_W-1:0]       cap;
  logic [CAP_W-1:0]       cnt_ext;
  logic                   is_empty;
  logic                   is_full;
  logic [IDX_W-1:0]       head_next;
  logic [CNT_W-1:0]       count_next;
  logic [31:0]            discards_rep;
  logic [CAP_W-1:0]       depth_ext;
  dopdq_pkg::res_t        res_next;

  // Configuration port: single register, writes complete in the access phase.
  assign pready = 1'b1;
  assign prdata = dopdq_pkg::PDATA_W'(max_depth);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= dopdq_pkg::MAX_DEPTH_RESET;
    end else if (psel && penable && pwrite && (paddr == dopdq_pkg::ADDR_MAX_DEPTH)) begin
      max_depth <= pwdata[8:0];
    end
  end

  // Handshake: a command is taken only while no other is in execution.
  assign cmd_stall = (state != ST_IDLE);
  assign cmd_take  = cmd_valid && (state == ST_IDLE);
  assign res_free  = !res_valid || !res_stall;
  assign exec_go   = (state == ST_EXEC) && res_free;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= cmd;
    end
  end

  // Store: head read on acceptance, write-back during execution.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      rdata <= store[head];
    end
    if (mem_we) begin
      store[mem_waddr] <= cmd_q.entry_in[ENTRY_WIDTH-1:0];
    end
  end

  // Ring index arithmetic.
  assign head_inc = (head == IDX_W'(STORE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? IDX_W'(STORE_DEPTH - 1) : head - 1'b1;
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (tail_sum >= SUM_W'(STORE_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(STORE_DEPTH)) : IDX_W'(tail_sum);

  // Effective back-push capacity: at least one, at most the store depth.
  assign md_ext  = CAP_W'(max_depth);
  assign cap     = (md_ext == '0) ? CAP_W'(1) :
                   (md_ext > CAP_W'(STORE_DEPTH)) ? CAP_W'(STORE_DEPTH) : md_ext;
  assign cnt_ext = CAP_W'(count);
  assign is_empty = (count == '0);
  assign is_full  = (count >= CNT_W'(STORE_DEPTH));

  // Operation decode and result build.
  always_comb begin
    head_next              = head;
    count_next             = count;
    discards_rep           = discards;
    mem_we                 = 1'b0;
    mem_waddr              = tail;
    res_next               = '0;
    res_next.status        = dopdq_pkg::STS_OK;
    case (cmd_q.action)
      dopdq_pkg::ACT_PUSH_BACK: begin
        mem_we = exec_go;
        if (cnt_ext >= cap) begin
          // Drop the oldest entry to make room; the depth is unchanged.
          head_next            = head_inc;
          res_next.entry_out   = 64'(rdata);
          res_next.entry_valid = 1'b1;
          res_next.evicted     = 1'b1;
          if (discards != '1) begin
            discards_rep = discards + 32'd1;
          end
        end else begin
          count_next = count + 1'b1;
        end
      end
      dopdq_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          res_next.status = dopdq_pkg::STS_FRONT_FULL;
        end else begin
          mem_we     = exec_go;
          mem_waddr  = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      dopdq_pkg::ACT_POP_FRONT, dopdq_pkg::ACT_PEEK_FRONT: begin
        if (is_empty) begin
          res_next.status = dopdq_pkg::STS_EMPTY;
        end else begin
          res_next.entry_out   = 64'(rdata);
          res_next.entry_valid = 1'b1;
          if (cmd_q.action == dopdq_pkg::ACT_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        // Status only, and the unused codes behave the same.
      end
    endcase
    depth_ext              = CAP_W'(count_next);
    res_next.depth         = depth_ext[8:0];
    res_next.discard_count = discards_rep;
  end

  // Sequencer and queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      discards <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state    <= ST_IDLE;
            head     <= head_next;
            count    <= count_next;
            discards <= cmd_q.clear_discards ? '0 : discards_rep;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec_go) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res <= res_next;
    end
  end

endmodule
